@@ rtl/nur_pkg.sv @@
// Shared types, constants and range helpers for the UTF-8 repair unit.
`timescale 1ns / 1ps
package nur_pkg;

  localparam int unsigned VARIANTS  = 4;
  localparam logic [5:0]  MAX_SCORE = 6'd48;
  localparam logic [7:0]  SCORE_TOP = 8'hff;
  localparam logic [7:0]  BYTE_TAB  = 8'h09;
  localparam logic [7:0]  BYTE_SPC  = 8'h20;

  typedef struct packed {
    logic [7:0] lead_lo;
    logic [7:0] lead_hi;
    logic [7:0] fol_lo;
    logic [7:0] fol_hi;
  } range_t;

  typedef struct packed {
    logic load;        // store one byte of the buffer
    logic in_rd;       // read input byte at pos + k
    logic acc;         // accumulate bit distances
    logic score_wr;    // write best score and variant
    logic place_init;  // clear filled marks and score level
    logic score_rd;    // read stored candidate
    logic place_wr;    // write clamped byte into the output store
    logic k_next;      // next byte of the span
    logic cand_next;   // next candidate in length-major order
    logic s_inc;       // next score level
    logic out_rd;      // read output store at pos
    logic emit;        // present one result
    logic emit_next;   // next output position
    logic done;        // buffer finished
  } cmd_t;

  typedef struct packed {
    logic load_done;
    logic k_last;
    logic pos_last;
    logic next_len_ok;
    logic s_last;
    logic match;
    logic emit_last;
  } stat_t;

  function automatic range_t get_range(input logic [1:0] len_m1, input logic [1:0] v);
    range_t r;
    r = '{8'h00, 8'h7f, 8'h00, 8'h00};
    case (len_m1)
      2'd0: r = '{8'h00, 8'h7f, 8'h00, 8'h00};
      2'd1: r = '{8'hc2, 8'hdf, 8'h80, 8'hbf};
      2'd2: begin
        case (v)
          2'd0: r = '{8'he0, 8'he0, 8'ha0, 8'hbf};
          2'd1: r = '{8'he1, 8'hec, 8'h80, 8'hbf};
          2'd2: r = '{8'hed, 8'hed, 8'h80, 8'h9f};
          default: r = '{8'hee, 8'hef, 8'h80, 8'hbf};
        endcase
      end
      default: begin
        case (v)
          2'd0: r = '{8'hf0, 8'hf0, 8'h90, 8'hbf};
          2'd1: r = '{8'hf1, 8'hf3, 8'h80, 8'hbf};
          default: r = '{8'hf4, 8'hf4, 8'h80, 8'h8f};
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [2:0] variant_count(input logic [1:0] len_m1);
    logic [2:0] c;
    case (len_m1)
      2'd0: c = 3'd1;
      2'd1: c = 3'd1;
      2'd2: c = 3'd4;
      default: c = 3'd3;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] fit(input logic [7:0] b, input logic [7:0] lo,
                                     input logic [7:0] hi);
    return (b > hi) ? hi : ((b < lo) ? lo : b);
  endfunction

  function automatic logic [7:0] clamp_byte(input logic [7:0] b, input range_t r,
                                            input logic lead);
    return lead ? fit(b, r.lead_lo, r.lead_hi) : fit(b, r.fol_lo, r.fol_hi);
  endfunction

  function automatic logic [3:0] ones8(input logic [7:0] b);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) c = c + {3'd0, b[i]};
    return c;
  endfunction

endpackage

@@ rtl/nur_ctrl.sv @@
// Sequencing state machine for the UTF-8 repair unit.
`timescale 1ns / 1ps
module nur_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  nur_pkg::stat_t st,
  output nur_pkg::cmd_t  cmd
);
  import nur_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SC_RD  = 10'b0000000010,
    S_SC_ACC = 10'b0000000100,
    S_SC_WR  = 10'b0000001000,
    S_PL_RD  = 10'b0000010000,
    S_PL_CHK = 10'b0000100000,
    S_PL_BRD = 10'b0001000000,
    S_PL_BWR = 10'b0010000000,
    S_EM_RD  = 10'b0100000000,
    S_EM_OUT = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (st.load_done) state_nxt = S_SC_RD;
        end
      end
      S_SC_RD: begin
        cmd.in_rd = 1'b1;
        state_nxt = S_SC_ACC;
      end
      S_SC_ACC: begin
        cmd.acc = 1'b1;
        if (st.k_last) state_nxt = S_SC_WR;
        else begin
          cmd.k_next = 1'b1;
          state_nxt  = S_SC_RD;
        end
      end
      S_SC_WR: begin
        cmd.score_wr  = 1'b1;
        cmd.cand_next = 1'b1;
        if (st.pos_last && !st.next_len_ok) begin
          cmd.place_init = 1'b1;
          state_nxt      = S_PL_RD;
        end else begin
          state_nxt = S_SC_RD;
        end
      end
      S_PL_RD: begin
        cmd.score_rd = 1'b1;
        state_nxt    = S_PL_CHK;
      end
      S_PL_CHK: begin
        if (st.match) state_nxt = S_PL_BRD;
        else begin
          cmd.cand_next = 1'b1;
          if (st.pos_last && !st.next_len_ok) begin
            if (st.s_last) state_nxt = S_EM_RD;
            else begin
              cmd.s_inc = 1'b1;
              state_nxt = S_PL_RD;
            end
          end else begin
            state_nxt = S_PL_RD;
          end
        end
      end
      S_PL_BRD: begin
        cmd.in_rd = 1'b1;
        state_nxt = S_PL_BWR;
      end
      S_PL_BWR: begin
        cmd.place_wr = 1'b1;
        if (st.k_last) begin
          cmd.cand_next = 1'b1;
          if (st.pos_last && !st.next_len_ok) begin
            if (st.s_last) state_nxt = S_EM_RD;
            else begin
              cmd.s_inc = 1'b1;
              state_nxt = S_PL_RD;
            end
          end else begin
            state_nxt = S_PL_RD;
          end
        end else begin
          cmd.k_next = 1'b1;
          state_nxt  = S_PL_BRD;
        end
      end
      S_EM_RD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = S_EM_OUT;
      end
      S_EM_OUT: begin
        cmd.emit = 1'b1;
        if (st.emit_last) begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.emit_next = 1'b1;
          state_nxt     = S_EM_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/nur_dp.sv @@
// Datapath of the UTF-8 repair unit: stores, counters, scoring and clamping.
`timescale 1ns / 1ps
module nur_dp #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  nur_pkg::cmd_t  cmd,
  output nur_pkg::stat_t st,
  input  logic [7:0]    in_byte,
  input  logic          in_last_byte,
  output logic          out_valid,
  output logic [7:0]    out_byte,
  output logic          out_last_out
);
  import nur_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_LEN);
  localparam int unsigned CW  = $clog2(MAX_LEN + 1);
  localparam int unsigned SD  = 4 * MAX_LEN;
  localparam int unsigned SIW = $clog2(SD);

  // Stores.
  logic [7:0] in_mem  [0:MAX_LEN-1];
  logic [7:0] out_mem [0:MAX_LEN-1];
  logic [9:0] sc_mem  [0:SD-1];
  logic [MAX_LEN-1:0] filled_r;

  logic [7:0] in_rd_r, out_rd_r;
  logic [9:0] sc_rd_r;

  // Counters.
  logic [CW-1:0] cnt_r;
  logic [1:0]    len_r;
  logic [AW-1:0] pos_r;
  logic [1:0]    k_r;
  logic [5:0]    s_r;
  logic [5:0]    dist_r [0:VARIANTS-1];

  logic [AW-1:0]  byte_addr;
  logic [SIW-1:0] sc_addr;
  logic [CW:0]    pos_end;
  range_t         rng_place;
  logic           span_free;

  assign byte_addr = AW'({1'b0, pos_r} + {{(AW-1){1'b0}}, k_r});
  assign sc_addr   = SIW'(SIW'(len_r) * SIW'(MAX_LEN)) + SIW'(pos_r);
  assign pos_end   = (CW+1)'(pos_r) + (CW+1)'(len_r) + (CW+1)'(1);

  always_comb begin
    logic [AW:0] idx;
    span_free = 1'b1;
    for (int j = 0; j < 4; j++) begin
      idx = (AW+1)'(pos_r) + (AW+1)'(j);
      if ((j <= int'(len_r)) && (idx < (AW+1)'(MAX_LEN)))
        if (filled_r[idx[AW-1:0]]) span_free = 1'b0;
    end
  end

  assign st.load_done   = in_last_byte || (cnt_r == CW'(MAX_LEN - 1));
  assign st.k_last      = (k_r == len_r);
  assign st.pos_last    = (pos_end == (CW+1)'(cnt_r));
  assign st.next_len_ok = (len_r != 2'd3) &&
                          ((CW+1)'(len_r) + (CW+1)'(2) <= (CW+1)'(cnt_r));
  assign st.s_last      = (s_r == MAX_SCORE);
  assign st.match       = (sc_rd_r[9:2] == {2'b00, s_r}) && span_free;
  assign st.emit_last   = ((CW+1)'(pos_r) + (CW+1)'(1) == (CW+1)'(cnt_r));

  assign rng_place = get_range(len_r, sc_rd_r[1:0]);

  // Best variant over the accumulated distances; length scaling is d*6/len.
  logic [7:0] best_sc;
  logic [1:0] best_v;
  always_comb begin
    logic [7:0] sc;
    logic [7:0] d;
    best_sc = SCORE_TOP;
    best_v  = 2'd0;
    for (int v = 0; v < VARIANTS; v++) begin
      d = {2'b00, dist_r[v]};
      case (len_r)
        2'd0: sc = 8'((d << 2) + (d << 1));
        2'd1: sc = 8'((d << 1) + d);
        2'd2: sc = 8'(d << 1);
        default: sc = 8'(((d << 1) + d) >> 1);
      endcase
      if ((3'(v) < variant_count(len_r)) && (sc < best_sc)) begin
        best_sc = sc;
        best_v  = 2'(v);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) in_mem[cnt_r[AW-1:0]] <= in_byte;
    if (cmd.in_rd) in_rd_r <= in_mem[byte_addr];
    if (cmd.score_wr) sc_mem[sc_addr] <= {best_sc, best_v};
    if (cmd.score_rd) sc_rd_r <= sc_mem[sc_addr];
    if (cmd.place_wr)
      out_mem[byte_addr] <= clamp_byte(in_rd_r, rng_place, k_r == 2'd0);
    if (cmd.out_rd) out_rd_r <= out_mem[pos_r];
    if (cmd.acc) begin
      for (int v = 0; v < VARIANTS; v++) begin
        dist_r[v] <= ((k_r == 2'd0) ? 6'd0 : dist_r[v]) +
                     6'(ones8(in_rd_r ^ clamp_byte(in_rd_r, get_range(len_r, 2'(v)),
                                                   k_r == 2'd0)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      len_r    <= '0;
      pos_r    <= '0;
      k_r      <= '0;
      s_r      <= '0;
      filled_r <= '0;
    end else begin
      if (cmd.load) begin
        cnt_r <= cnt_r + CW'(1);
        len_r <= '0;
        pos_r <= '0;
        k_r   <= '0;
      end
      if (cmd.done) cnt_r <= '0;
      if (cmd.k_next) k_r <= k_r + 2'd1;
      if (cmd.cand_next) begin
        k_r <= '0;
        if (st.pos_last && st.next_len_ok) begin
          len_r <= len_r + 2'd1;
          pos_r <= '0;
        end else if (st.pos_last) begin
          len_r <= '0;
          pos_r <= '0;
        end else begin
          pos_r <= pos_r + AW'(1);
        end
      end
      if (cmd.place_init) begin
        filled_r <= '0;
        s_r      <= '0;
      end
      if (cmd.s_inc) s_r <= s_r + 6'd1;
      if (cmd.place_wr) filled_r[byte_addr] <= 1'b1;
      if (cmd.emit_next) pos_r <= pos_r + AW'(1);
    end
  end

  assign out_valid    = cmd.emit;
  assign out_byte     = ((out_rd_r < BYTE_TAB) ||
                         ((out_rd_r > BYTE_TAB) && (out_rd_r < BYTE_SPC))) ?
                        BYTE_SPC : out_rd_r;
  assign out_last_out = st.emit_last;

endmodule

@@ rtl/nearest_utf8_repair_unit.sv @@
// Top level of the nearest UTF-8 repair unit.
`timescale 1ns / 1ps
// Usage: bytes of a buffer arrive one per transaction on in_byte, accepted at
// a rising edge where start is high and busy is low. in_last_byte marks the
// final byte; a buffer of MAX_LEN bytes ends on its last byte regardless.
// While loading, busy stays low and one byte is taken per cycle.
// After the final byte busy rises and the unit scores every span of one to
// four bytes against the legal UTF-8 lead and continuation ranges, then
// places the lowest-scoring free spans, level by level from score 0 to 48.
// Scoring reads each byte of a candidate from the input store, accumulates
// its bit distance for every variant, then writes the best score and variant.
// Placement sweeps all candidates once per score level (49 levels, one score
// store read per candidate), and each placed byte is read from the input
// store and written clamped into the output store.
// The repaired buffer then leaves as one result transaction per byte, each
// shown for one cycle with out_valid high; out_last_out marks the last. The
// receiver cannot stall, so no result is ever held back.
// Synchronous reset empties the buffer and returns the unit to loading;
// the stores themselves are not cleared, as nothing is read before written.
module nearest_utf8_repair_unit #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_last_out
);
  import nur_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // The controller sequences load, scoring, placement and emission.
  nur_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // The datapath holds the stores, counters and scoring arithmetic.
  nur_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .out_last_out (out_last_out)
  );

endmodule

@@ dv/nearest_utf8_repair_unit_tb.sv @@
// Self-checking testbench for the nearest UTF-8 repair unit.
`timescale 1ns / 1ps
module nearest_utf8_repair_unit_tb;

  localparam int unsigned BUF_MAX = 64;
  // Generous ceiling on the length of the whole run.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // One entry of the lead/continuation range table used by the predictor.
  typedef struct packed {
    logic [7:0] lead_lo;
    logic [7:0] lead_hi;
    logic [7:0] cont_lo;
    logic [7:0] cont_hi;
  } utf8_range_t;

  // A byte to load, with its end-of-buffer mark.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } load_txn_t;

  // One expected repaired byte.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } repaired_txn_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [7:0] in_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last_out;

  load_txn_t     load_queue[$];
  repaired_txn_t repaired_queue[$];

  // Predictor state: the bytes of the buffer being loaded.
  logic [7:0]  pending_buf[$];

  int unsigned cycle_count;
  int unsigned error_count;
  bit          quiet_stretch;

  nearest_utf8_repair_unit #(
    .MAX_LEN(BUF_MAX)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_byte     (in_byte),
    .in_last_byte(in_last_byte),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .out_last_out(out_last_out)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Range table indexed by length and variant.
  function automatic utf8_range_t utf8_range(input int len, input int v);
    utf8_range_t r;
    r = '{8'h00, 8'h7f, 8'h00, 8'h00};
    if (len == 2) begin
      r = '{8'hc2, 8'hdf, 8'h80, 8'hbf};
    end else if (len == 3) begin
      case (v)
        0: r = '{8'he0, 8'he0, 8'ha0, 8'hbf};
        1: r = '{8'he1, 8'hec, 8'h80, 8'hbf};
        2: r = '{8'hed, 8'hed, 8'h80, 8'h9f};
        default: r = '{8'hee, 8'hef, 8'h80, 8'hbf};
      endcase
    end else if (len == 4) begin
      case (v)
        0: r = '{8'hf0, 8'hf0, 8'h90, 8'hbf};
        1: r = '{8'hf1, 8'hf3, 8'h80, 8'hbf};
        default: r = '{8'hf4, 8'hf4, 8'h80, 8'h8f};
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] clamp8(input logic [7:0] b, input logic [7:0] lo,
                                        input logic [7:0] hi);
    if (b > hi) return hi;
    if (b < lo) return lo;
    return b;
  endfunction

  function automatic logic [7:0] clamp_at(input logic [7:0] b, input utf8_range_t r,
                                          input int k);
    return (k == 0) ? clamp8(b, r.lead_lo, r.lead_hi) : clamp8(b, r.cont_lo, r.cont_hi);
  endfunction

  // Repairs the whole buffer in pending_buf and queues the expected bytes.
  task automatic repair_buffer();
    int          n;
    int          nvar;
    int          flip_count;
    logic [7:0]  sc;
    logic [7:0]  best_score[4][BUF_MAX];
    int          best_var[4][BUF_MAX];
    logic [7:0]  fixed[BUF_MAX];
    bit          filled[BUF_MAX];
    bit          span_ok;
    utf8_range_t r;
    logic [7:0]  b;
    repaired_txn_t t;
    n = pending_buf.size();
    for (int len = 1; len <= 4; len++) begin
      nvar = (len == 3) ? 4 : ((len == 4) ? 3 : 1);
      for (int p = 0; p + len <= n; p++) begin
        best_score[len-1][p] = 8'hff;
        best_var[len-1][p] = 0;
        for (int v = 0; v < nvar; v++) begin
          r = utf8_range(len, v);
          flip_count = 0;
          for (int k = 0; k < len; k++)
            flip_count += $countones(pending_buf[p+k] ^ clamp_at(pending_buf[p+k], r, k));
          sc = 8'(flip_count * 6 / len);
          if (best_score[len-1][p] > sc) begin
            best_score[len-1][p] = sc;
            best_var[len-1][p] = v;
          end
        end
      end
    end
    for (int i = 0; i < BUF_MAX; i++) filled[i] = 1'b0;
    // Lowest score first; ties go length-major, then by position.
    for (int s = 0; s < 256; s++) begin
      for (int len = 1; len <= 4; len++) begin
        for (int p = 0; p + len <= n; p++) begin
          if (best_score[len-1][p] == s) begin
            span_ok = 1'b1;
            for (int k = 0; k < len; k++) if (filled[p+k]) span_ok = 1'b0;
            if (span_ok) begin
              r = utf8_range(len, best_var[len-1][p]);
              for (int k = 0; k < len; k++) begin
                fixed[p+k] = clamp_at(pending_buf[p+k], r, k);
                filled[p+k] = 1'b1;
              end
            end
          end
        end
      end
    end
    // Control bytes below 0x20 other than tab are turned into spaces.
    for (int k = 0; k < n; k++) begin
      b = fixed[k];
      if (b < 8'h09 || (b > 8'h09 && b < 8'h20)) b = 8'h20;
      t.data = b;
      t.last = (k + 1 == n);
      repaired_queue.push_back(t);
    end
    pending_buf.delete();
  endtask

  // Accounts one accepted load transaction in the predictor.
  task automatic accept_byte(input load_txn_t t);
    pending_buf.push_back(t.data);
    if (t.last || pending_buf.size() >= BUF_MAX) repair_buffer();
  endtask

  // Queues one buffer of the given length with random, printable ASCII or UTF-8-shaped content.
  task automatic queue_buffer(input int len, input int flavor);
    load_txn_t t;
    for (int i = 0; i < len; i++) begin
      case (flavor)
        0: t.data = 8'($urandom);
        1: t.data = 8'($urandom_range(8'h20, 8'h7e));
        // Mostly well-formed UTF-8 shapes with occasional noise.
        default: begin
          case ($urandom_range(0, 4))
            0: t.data = 8'($urandom_range(8'h00, 8'h7f));
            1: t.data = 8'($urandom_range(8'hc0, 8'hdf));
            2: t.data = 8'($urandom_range(8'he0, 8'hef));
            3: t.data = 8'($urandom_range(8'hf0, 8'hff));
            default: t.data = 8'($urandom_range(8'h80, 8'hbf));
          endcase
        end
      endcase
      // Full buffers end on their own; sometimes leave the mark low to show it.
      t.last = (i == len - 1) ? ((len == BUF_MAX) ? 1'($urandom) : 1'b1) : 1'b0;
      load_queue.push_back(t);
    end
  endtask

  // Driver: presents queued bytes, idling at random outside the quiet stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      start        <= 1'b0;
      in_byte      <= 8'h00;
      in_last_byte <= 1'b0;
    end else begin
      if (start && !busy) begin
        accept_byte('{in_byte, in_last_byte});
        void'(load_queue.pop_front());
      end
      if (load_queue.size() > 0 && (quiet_stretch || $urandom_range(0, 99) >= 26)) begin
        start        <= 1'b1;
        in_byte      <= load_queue[0].data;
        in_last_byte <= load_queue[0].last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // The driver must not re-present an item that has just been taken: it pops
  // the entry at the edge that accepts it, and what it drives at that same
  // edge is the next entry, so each load transaction goes in once.

  // Monitor: every strobed result is compared with the oldest expected byte.
  always @(posedge clk) begin
    repaired_txn_t exp_t;
    if (rst_n && out_valid) begin
      if (repaired_queue.size() == 0) begin
        $error("unexpected result: out_byte=%02h out_last_out=%0b", out_byte, out_last_out);
        error_count++;
      end else begin
        exp_t = repaired_queue.pop_front();
        if (out_byte !== exp_t.data) begin
          $error("out_byte mismatch: expected %02h actual %02h", exp_t.data, out_byte);
          error_count++;
        end
        if (out_last_out !== exp_t.last) begin
          $error("out_last_out mismatch: expected %0b actual %0b", exp_t.last,
                 out_last_out);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("nearest_utf8_repair_unit test failed");
      $finish;
    end
  end

  initial begin
    int queued;
    int len;
    cycle_count   = 0;
    error_count   = 0;
    quiet_stretch = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_byte       = 8'h00;
    in_last_byte  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: field extremes, single-byte buffers, a control byte, a tab,
    // well-formed sequences, and a buffer that hits full length without a mark.
    load_queue.push_back('{8'h00, 1'b1});
    load_queue.push_back('{8'hff, 1'b1});
    load_queue.push_back('{8'h09, 1'b1});
    load_queue.push_back('{8'h1f, 1'b1});
    load_queue.push_back('{8'h7f, 1'b0});
    load_queue.push_back('{8'h80, 1'b1});
    load_queue.push_back('{8'he2, 1'b0});
    load_queue.push_back('{8'h82, 1'b0});
    load_queue.push_back('{8'hac, 1'b1});
    load_queue.push_back('{8'hf0, 1'b0});
    load_queue.push_back('{8'h9f, 1'b0});
    load_queue.push_back('{8'h98, 1'b0});
    load_queue.push_back('{8'h80, 1'b1});
    load_queue.push_back('{8'hed, 1'b0});
    load_queue.push_back('{8'ha0, 1'b0});
    load_queue.push_back('{8'h80, 1'b1});
    for (int i = 0; i < BUF_MAX; i++)
      load_queue.push_back('{8'($urandom), 1'b0});

    // Random part: mostly short buffers, a few full ones.
    queued = 16 + BUF_MAX;
    while (queued < 410) begin
      len = ($urandom_range(0, 19) == 0) ? BUF_MAX : $urandom_range(1, 12);
      queue_buffer(len, $urandom_range(0, 3));
      queued += len;
    end

    // Middle stretch of the load runs without any idle cycles.
    wait (load_queue.size() < 250);
    quiet_stretch = 1'b1;
    wait (load_queue.size() < 120);
    quiet_stretch = 1'b0;

    wait (load_queue.size() == 0 && !start);
    wait (repaired_queue.size() == 0 && pending_buf.size() == 0);
    repeat (50) @(posedge clk);
    if (error_count == 0 && repaired_queue.size() == 0 && pending_buf.size() == 0) begin
      $display("nearest_utf8_repair_unit test passed");
    end else begin
      $display("nearest_utf8_repair_unit test failed");
    end
    $finish;
  end

endmodule
